// ===== hdl/tfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tfs_pkg;

   localparam int PACKET_BYTES = 8;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;
   localparam logic [7:0] CSUM_BASE = 8'hFF;

   // one classified packet byte, handed from the front to the back
   typedef struct packed {
      logic [7:0] data;
      logic       is_id;
      logic       is_last;
      logic [7:0] csum;
   } entry_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_DATA_ESC,
      PH_SUM,
      PH_SUM_ESC
   } phase_type;

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/tfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tfs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;

   modport source (output valid, output packet_byte, input ready);
   modport sink   (input valid, input packet_byte, output ready);
endinterface

interface tfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       run_last;
   logic       frame_end;

   modport source (output valid, output line_byte, output run_last, output frame_end,
                   input ready);
   modport sink   (input valid, input line_byte, input run_last, input frame_end,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/tfs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfs_front #(
   parameter int PacketBytes = tfs_pkg::PACKET_BYTES
) (
   input  wire logic          clock,
   input  wire logic          reset,
   tfs_req_if.sink            req_chan,
   input  wire logic          q_full,
   output logic               push_valid,
   output tfs_pkg::entry_type push_entry
);

   localparam int PosW = (PacketBytes > 2) ? $clog2(PacketBytes) : 1;

   logic [PosW-1:0] pos_ff, pos_in;
   logic [7:0]      sum_ff, sum_in;
   logic [8:0]      sum_wide;
   logic [7:0]      sum_new;
   logic            is_id;
   logic            is_last;

   assign req_chan.ready = !q_full;
   assign push_valid     = req_chan.valid && !q_full;

   always_comb begin
      is_id    = (pos_ff == '0);
      is_last  = !is_id && (pos_ff >= PosW'(PacketBytes - 1));
      // end-around carry: fold bit 8 back into the low byte
      sum_wide = {1'b0, sum_ff} + {1'b0, req_chan.packet_byte};
      sum_new  = sum_wide[7:0] + {7'b0, sum_wide[8]};

      push_entry.data    = req_chan.packet_byte;
      push_entry.is_id   = is_id;
      push_entry.is_last = is_last;
      push_entry.csum    = tfs_pkg::CSUM_BASE - sum_new;
   end

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (push_valid) begin
         if (is_id) begin
            pos_in = PosW'(1);
         end else if (is_last) begin
            pos_in = '0;
            sum_in = '0;
         end else begin
            pos_in = pos_ff + PosW'(1);
            sum_in = sum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tfs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfs_queue #(
   parameter int Depth = tfs_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tfs_pkg::entry_type push_entry,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output tfs_pkg::entry_type      head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tfs_pkg::entry_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tfs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tfs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire tfs_pkg::entry_type head,
   output logic                    pop,
   tfs_rsp_if.source               rsp_chan
);

   tfs_pkg::phase_type phase_ff, phase_in;

   logic       valid_ff, valid_in;
   logic [7:0] line_ff, line_in;
   logic       last_ff, last_in;
   logic       fend_ff, fend_in;

   logic       advance;
   logic [7:0] word;
   logic       word_last;
   logic       word_fend;

   // the output register takes a new word when empty or being drained
   assign advance = !q_empty && (!valid_ff || rsp_chan.ready);
   assign pop     = advance && word_last;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         case (phase_ff)
            tfs_pkg::PH_DATA: begin
               if (!head.is_id && tfs_pkg::needs_escape(head.data)) begin
                  phase_in = tfs_pkg::PH_DATA_ESC;
               end else if (!head.is_id && head.is_last) begin
                  phase_in = tfs_pkg::PH_SUM;
               end else begin
                  phase_in = tfs_pkg::PH_DATA;
               end
            end
            tfs_pkg::PH_DATA_ESC: begin
               phase_in = head.is_last ? tfs_pkg::PH_SUM : tfs_pkg::PH_DATA;
            end
            tfs_pkg::PH_SUM: begin
               phase_in = tfs_pkg::needs_escape(head.csum) ? tfs_pkg::PH_SUM_ESC
                                                          : tfs_pkg::PH_DATA;
            end
            tfs_pkg::PH_SUM_ESC: begin
               phase_in = tfs_pkg::PH_DATA;
            end
            default: begin
               phase_in = tfs_pkg::PH_DATA;
            end
         endcase
      end
   end

   // word produced in the current phase
   always_comb begin
      word      = head.data;
      word_last = 1'b0;
      word_fend = 1'b0;
      case (phase_ff)
         tfs_pkg::PH_DATA: begin
            if (head.is_id) begin
               word      = head.data;
               word_last = 1'b1;
            end else if (tfs_pkg::needs_escape(head.data)) begin
               word = tfs_pkg::ESC_BYTE;
            end else begin
               word      = head.data;
               word_last = !head.is_last;
            end
         end
         tfs_pkg::PH_DATA_ESC: begin
            word      = head.data ^ tfs_pkg::ESC_XOR;
            word_last = !head.is_last;
         end
         tfs_pkg::PH_SUM: begin
            if (tfs_pkg::needs_escape(head.csum)) begin
               word = tfs_pkg::ESC_BYTE;
            end else begin
               word      = head.csum;
               word_last = 1'b1;
               word_fend = 1'b1;
            end
         end
         tfs_pkg::PH_SUM_ESC: begin
            word      = head.csum ^ tfs_pkg::ESC_XOR;
            word_last = 1'b1;
            word_fend = 1'b1;
         end
         default: begin
            word      = head.data;
            word_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      line_in  = line_ff;
      last_in  = last_ff;
      fend_in  = fend_ff;
      if (advance) begin
         valid_in = 1'b1;
         line_in  = word;
         last_in  = word_last;
         fend_in  = word_fend;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tfs_pkg::PH_DATA;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      last_ff <= last_in;
      fend_ff <= fend_in;
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.line_byte = line_ff;
   assign rsp_chan.run_last  = last_ff;
   assign rsp_chan.frame_end = fend_ff;

endmodule

`default_nettype wire

// ===== hdl/telemetry_frame_stuffer.sv =====
// A packet byte accepted into a queue slot is expanded from the queue head, and each line word
// is registered in the output register before it reaches the result port.
// The output register gives one line word per cycle while the receiver holds ready and the queue
// is not empty; a packet byte makes 1 to 4 words (id 1, middle byte 1 or 2, last byte 2 to 4).
// The two-entry queue lets new bytes in while earlier ones are still being expanded.
// Reset (synchronous, active high) empties the queue and output register and waits for an id.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_stuffer #(
   parameter int PacketBytes = tfs_pkg::PACKET_BYTES
) (
   input  wire logic clock,
   input  wire logic reset,
   tfs_req_if.sink   req_chan,
   tfs_rsp_if.source rsp_chan
);

   logic               push_valid;
   tfs_pkg::entry_type push_entry;
   logic               q_full;
   logic               q_empty;
   logic               pop;
   tfs_pkg::entry_type head;

   tfs_front #(
      .PacketBytes(PacketBytes)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   tfs_queue #(
      .Depth(tfs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   tfs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
